>>> hw/rtl/pttt_pkg.sv
package pttt_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int QDEPTH = 8;
   localparam logic [31:0] HALF_RANGE = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      REQ_ADD     = 2'd0,
      REQ_TICK    = 2'd1,
      REQ_SERVICE = 2'd2,
      REQ_DELAY   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_PRESENT     = 2'd1,
      ST_NOT_ACTIVE  = 2'd2,
      ST_NOTHING     = 2'd3
   } status_type;

   // Request as held in the queue between front and back
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  slot;
      logic [31:0] time_now;
      logic [31:0] period;
      logic [15:0] recurrences;
      logic        start_enabled;
      logic [31:0] delay_amount;
      logic        delay_by_period;
   } req_type;

   // Runs again: enabled and count positive or forever
   function automatic logic runs_again(input logic en, input logic [15:0] r);
      runs_again = en && (((r != 16'd0) && !r[15]) || (r == 16'hFFFF));
   endfunction

endpackage

>>> hw/rtl/pttt_front.sv
// Front end: takes requests into a two-entry queue
module pttt_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  pttt_pkg::req_type     in_req,
   output logic                  out_valid,
   input  logic                  out_pop,
   output pttt_pkg::req_type     out_req
);
   pttt_pkg::req_type q_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push;

   assign in_stall  = (cnt_ff == 2'd2);
   assign push      = in_valid && !in_stall;
   assign out_valid = (cnt_ff != 2'd0);
   assign out_req   = q_ff[rd_ff];

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= in_req;
   end

   // Pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (out_pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, out_pop};
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      out_pop |-> out_valid) else $error("pop from empty queue");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue overfill");
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      in_stall |-> out_valid) else $error("stall without entries");
endmodule

>>> hw/rtl/pttt_back.sv
// Back end: runs one request at a time against the task table
module pttt_back #(
   parameter int SLOTS = pttt_pkg::SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_pop,
   input  pttt_pkg::req_type     in_req,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [2:0]            rsp_task_slot,
   output logic                  rsp_fired,
   output logic                  rsp_runs_again,
   output logic [31:0]           rsp_next_due,
   output logic                  rsp_last
);
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SCW = $clog2(SLOTS + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_TICK = 4'b0010,
      S_SERV = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [SLOTS-1:0] active_ff, enabled_ff, queued_ff;
   logic [31:0] period_ff [SLOTS];
   logic [15:0] remain_ff [SLOTS];
   logic [31:0] due_ff    [SLOTS];
   logic [2:0]  runq_ff   [pttt_pkg::QDEPTH];
   logic [3:0]  qcount_ff;
   logic        ticked_ff;

   pttt_pkg::req_type cur_ff;
   logic [SCW-1:0] idx_ff;
   logic [3:0]     qidx_ff;

   // Output register
   logic        ov_ff;
   logic [1:0]  ost_ff;
   logic [2:0]  oslot_ff;
   logic        ofired_ff, ora_ff, olast_ff;
   logic [31:0] odue_ff;
   logic        ov_set;

   assign rsp_valid      = ov_ff;
   assign rsp_status     = ost_ff;
   assign rsp_task_slot  = oslot_ff;
   assign rsp_fired      = ofired_ff;
   assign rsp_runs_again = ora_ff;
   assign rsp_next_due   = odue_ff;
   assign rsp_last       = olast_ff;

   logic out_free;
   assign out_free = !ov_ff || !rsp_stall;
   assign in_pop   = (state_ff == S_IDLE) && in_valid && out_free;

   // Per-request helpers
   logic [SW-1:0] rs;
   logic          slot_ok;
   logic [2:0]    svc_slot;
   logic [SW-1:0] ss, ts;
   logic [15:0]   cur_r, dec_r;
   logic          dec_en, svc_ra;
   logic [31:0]   dly_due, tick_diff;
   logic          tick_hit;

   assign slot_ok  = ({29'd0, in_req.slot} < 32'(SLOTS));
   assign rs       = SW'(in_req.slot);
   assign svc_slot = runq_ff[qidx_ff[2:0]];
   assign ss       = SW'(svc_slot);
   assign ts       = SW'(idx_ff);
   assign cur_r    = remain_ff[ss];
   assign dec_r    = (cur_r != 16'd0 && !cur_r[15]) ? cur_r - 16'd1 : cur_r;
   assign dec_en   = enabled_ff[ss] && (dec_r != 16'd0);
   assign svc_ra   = pttt_pkg::runs_again(dec_en, enabled_ff[ss] ? dec_r : cur_r);
   assign dly_due  = in_req.delay_by_period ? in_req.time_now + period_ff[rs]
                   : (enabled_ff[rs] ? due_ff[rs] : in_req.time_now)
                     + in_req.delay_amount;
   assign tick_diff = cur_ff.time_now - due_ff[ts];
   assign tick_hit  = active_ff[ts] && enabled_ff[ts] && !queued_ff[ts]
                    && (tick_diff < pttt_pkg::HALF_RANGE)
                    && (qcount_ff < 4'(pttt_pkg::QDEPTH));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (in_pop) begin
            if (in_req.kind == pttt_pkg::REQ_TICK) state_in = S_TICK;
            else if (in_req.kind == pttt_pkg::REQ_SERVICE && ticked_ff
                     && qcount_ff != 4'd0) state_in = S_SERV;
         end
         S_TICK: if (idx_ff == SCW'(SLOTS - 1)) state_in = S_OUT;
         S_SERV: if (out_free && qidx_ff + 4'd1 == qcount_ff) state_in = S_IDLE;
         S_OUT:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Result register load: every popped request except a tick or a real
   // service run answers at once; service and tick end answer when free
   always_comb begin
      ov_set = 1'b0;
      unique case (state_ff)
         S_IDLE: ov_set = in_pop && (in_req.kind != pttt_pkg::REQ_TICK)
                          && !(in_req.kind == pttt_pkg::REQ_SERVICE && ticked_ff
                               && qcount_ff != 4'd0);
         S_SERV, S_OUT: ov_set = out_free;
         default: ov_set = 1'b0;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         active_ff <= '0; enabled_ff <= '0; queued_ff <= '0;
         qcount_ff <= '0; ticked_ff <= 1'b0; ov_ff <= 1'b0;
         idx_ff <= '0; qidx_ff <= '0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_set || (ov_ff && rsp_stall);
         unique case (state_ff)
            S_IDLE: if (in_pop) begin
               cur_ff  <= in_req;
               idx_ff  <= '0;
               qidx_ff <= '0;
               unique case (in_req.kind)
                  pttt_pkg::REQ_TICK: ;
                  pttt_pkg::REQ_SERVICE: begin
                     if (!(ticked_ff && qcount_ff != 4'd0)) begin
                        ost_ff <= pttt_pkg::ST_NOTHING;
                        oslot_ff <= '0; ofired_ff <= 1'b0; ora_ff <= 1'b0;
                        odue_ff <= '0; olast_ff <= 1'b1;
                     end
                  end
                  pttt_pkg::REQ_ADD: begin
                     olast_ff <= 1'b1; ofired_ff <= 1'b0;
                     oslot_ff <= in_req.slot;
                     if (!slot_ok) begin
                        ost_ff <= pttt_pkg::ST_NOT_ACTIVE; ora_ff <= 1'b0;
                        odue_ff <= '0;
                     end else if (active_ff[rs]) begin
                        ost_ff <= pttt_pkg::ST_PRESENT;
                        ora_ff <= pttt_pkg::runs_again(enabled_ff[rs], remain_ff[rs]);
                        odue_ff <= due_ff[rs];
                     end else begin
                        ost_ff <= pttt_pkg::ST_OK;
                        active_ff[rs]  <= 1'b1;
                        enabled_ff[rs] <= in_req.start_enabled;
                        queued_ff[rs]  <= 1'b0;
                        period_ff[rs]  <= in_req.period;
                        remain_ff[rs]  <= in_req.recurrences;
                        due_ff[rs] <= in_req.start_enabled
                                      ? in_req.time_now + in_req.period : '0;
                        ora_ff  <= pttt_pkg::runs_again(in_req.start_enabled,
                                                        in_req.recurrences);
                        odue_ff <= in_req.start_enabled
                                   ? in_req.time_now + in_req.period : '0;
                     end
                  end
                  pttt_pkg::REQ_DELAY: begin
                     olast_ff <= 1'b1; ofired_ff <= 1'b0;
                     oslot_ff <= in_req.slot;
                     if (!slot_ok || !active_ff[rs]) begin
                        ost_ff <= pttt_pkg::ST_NOT_ACTIVE; ora_ff <= 1'b0;
                        odue_ff <= '0;
                     end else begin
                        ost_ff <= pttt_pkg::ST_OK;
                        due_ff[rs] <= dly_due;
                        enabled_ff[rs] <= 1'b1;
                        ora_ff  <= pttt_pkg::runs_again(1'b1, remain_ff[rs]);
                        odue_ff <= dly_due;
                     end
                  end
                  default: ;
               endcase
            end
            S_TICK: begin
               if (tick_hit) begin
                  runq_ff[qcount_ff[2:0]] <= 3'(idx_ff);
                  qcount_ff <= qcount_ff + 4'd1;
                  queued_ff[ts] <= 1'b1;
               end
               idx_ff <= idx_ff + SCW'(1);
               if (idx_ff == SCW'(SLOTS - 1)) ticked_ff <= 1'b1;
            end
            S_SERV: if (out_free) begin
               if (enabled_ff[ss]) begin
                  remain_ff[ss] <= dec_r;
                  if (dec_r == 16'd0) enabled_ff[ss] <= 1'b0;
               end
               due_ff[ss] <= svc_ra ? cur_ff.time_now + period_ff[ss] : '0;
               queued_ff[ss] <= 1'b0;
               ost_ff <= pttt_pkg::ST_OK; oslot_ff <= svc_slot;
               ofired_ff <= 1'b1; ora_ff <= svc_ra;
               odue_ff <= svc_ra ? cur_ff.time_now + period_ff[ss] : '0;
               olast_ff <= (qidx_ff + 4'd1 == qcount_ff);
               qidx_ff <= qidx_ff + 4'd1;
               if (qidx_ff + 4'd1 == qcount_ff) qcount_ff <= '0;
            end
            S_OUT: if (out_free) begin
               ost_ff <= pttt_pkg::ST_OK; oslot_ff <= '0;
               ofired_ff <= 1'b0; ora_ff <= 1'b0; odue_ff <= '0;
               olast_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   a_qcount: assert property (@(posedge clock) disable iff (reset)
      qcount_ff <= 4'(pttt_pkg::QDEPTH)) else $error("queue count overflow");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && rsp_stall |=> ov_ff && $stable(odue_ff))
      else $error("result changed while stalled");
   a_fired_ok: assert property (@(posedge clock) disable iff (reset)
      ov_ff && ofired_ff |-> ost_ff == pttt_pkg::ST_OK)
      else $error("fired result with bad status");
   a_serv_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SERV |-> qcount_ff != 4'd0 && ticked_ff)
      else $error("service with empty queue");
endmodule

>>> hw/rtl/periodic_task_timer_table.sv
// Periodic task timer table: SLOTS tasks, each with period, run count and
// due time. With the back end idle, an add or delay request passes the
// request queue and is answered from the result register; a tick walks
// every slot, one per cycle, then gives a single result; a service request
// gives one result per queued task, one per cycle while the result side
// takes them. A two-entry request queue in front lets requests arrive
// while the back end is still busy. Results on rsp_ mark the final one of
// a request with last.
module periodic_task_timer_table #(
   parameter int SLOTS = pttt_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_req_type,
   input  logic [2:0]  req_slot,
   input  logic [31:0] req_time_now,
   input  logic [31:0] req_period,
   input  logic signed [15:0] req_recurrences,
   input  logic        req_start_enabled,
   input  logic [31:0] req_delay_amount,
   input  logic        req_delay_by_period,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_task_slot,
   output logic        rsp_fired,
   output logic        rsp_runs_again,
   output logic [31:0] rsp_next_due,
   output logic        rsp_last
);
   pttt_pkg::req_type in_req, q_req;
   logic q_valid, q_pop;

   assign in_req = '{kind: req_req_type, slot: req_slot, time_now: req_time_now,
                     period: req_period, recurrences: req_recurrences,
                     start_enabled: req_start_enabled,
                     delay_amount: req_delay_amount,
                     delay_by_period: req_delay_by_period};

   pttt_front u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall), .in_req(in_req),
      .out_valid(q_valid), .out_pop(q_pop), .out_req(q_req)
   );

   pttt_back #(.SLOTS(SLOTS)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_pop(q_pop), .in_req(q_req),
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_task_slot, .rsp_fired,
      .rsp_runs_again, .rsp_next_due, .rsp_last
   );
endmodule
